/* hw/rtl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* hw/rtl/mrd_pkg.sv */
`default_nettype none

package mrd_pkg;

    // Record kinds as they appear on the result side
    localparam logic [3:0] KIND_END        = 4'd0;
    localparam logic [3:0] KIND_VOLT_CPLX  = 4'd2;
    localparam logic [3:0] KIND_IMP_MAG    = 4'd3;
    localparam logic [3:0] KIND_IMP_CPLX   = 4'd4;
    localparam logic [3:0] KIND_OTHER_CPLX = 4'd6;
    localparam logic [3:0] KIND_EIT        = 4'd7;
    localparam logic [3:0] KIND_BAD        = 4'd8;

    localparam logic [7:0] TYPE_MAX = 8'd7;

    // Payload bytes after the type byte
    localparam logic [3:0] MAG_LEN  = 4'd7;
    localparam logic [3:0] CPLX_LEN = 4'd11;
    localparam logic [3:0] ELEC_BYTES = 4'd3;

    localparam int QDEPTH = 4;

    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  src;
        logic [7:0]  snk;
        logic [7:0]  meas;
        logic [63:0] value;
        logic        cplx;
    } t_rec;

endpackage

`default_nettype wire

/* hw/rtl/mrd_queue.sv */
`default_nettype none

module mrd_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  mrd_pkg::t_rec      i_rec,
    output logic               o_full,
    output logic               o_valid,
    output mrd_pkg::t_rec      o_rec,
    input  wire logic          i_pop
);
    import mrd_pkg::*;

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W = $clog2(QDEPTH + 1);

    t_rec             r_mem [QDEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_rec   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mrd_front.sv */
`default_nettype none

module mrd_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [7:0]    i_byte,
    input  wire logic          i_full,
    output logic               o_stall,
    output logic               o_push,
    output mrd_pkg::t_rec      o_rec
);
    import mrd_pkg::*;

    logic [3:0]  r_pos, n_pos;
    logic [2:0]  r_kind, n_kind;
    logic [7:0]  r_elec [3];
    logic [7:0]  n_elec [3];
    logic [63:0] r_value, n_value;

    logic       accept;
    logic [3:0] idx;
    logic [2:0] vidx;
    logic       cplx;
    logic [3:0] len;

    assign o_stall = i_full;
    assign accept  = i_valid & ~i_full;
    assign idx     = r_pos - 4'd1;
    assign vidx    = 3'(idx - ELEC_BYTES);
    assign cplx    = ~r_kind[0];
    assign len     = cplx ? CPLX_LEN : MAG_LEN;

    always_comb begin
        n_pos   = r_pos;
        n_kind  = r_kind;
        n_elec  = r_elec;
        n_value = r_value;
        o_push  = 1'b0;
        o_rec   = '0;
        if (accept) begin
            if (r_pos == 4'd0) begin
                if (i_byte == 8'd0) begin
                    o_push     = 1'b1;
                    o_rec.kind = KIND_END;
                end else if (i_byte > TYPE_MAX) begin
                    o_push     = 1'b1;
                    o_rec.kind = KIND_BAD;
                end else begin
                    n_kind  = i_byte[2:0];
                    n_value = '0;
                    n_pos   = 4'd1;
                end
            end else begin
                if (idx < ELEC_BYTES) begin
                    n_elec[idx[1:0]] = i_byte;
                end else begin
                    n_value[8*vidx +: 8] = i_byte;
                end
                if (idx + 4'd1 < len) begin
                    n_pos = r_pos + 4'd1;
                end else begin
                    // last byte: hand the finished record to the queue
                    n_pos       = 4'd0;
                    o_push      = 1'b1;
                    o_rec.kind  = {1'b0, r_kind};
                    o_rec.src   = n_elec[0];
                    o_rec.snk   = n_elec[1];
                    o_rec.meas  = n_elec[2];
                    o_rec.value = n_value;
                    o_rec.cplx  = cplx;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_kind  <= '0;
            r_elec  <= '{default: '0};
            r_value <= '0;
        end else begin
            r_pos   <= n_pos;
            r_kind  <= n_kind;
            r_elec  <= n_elec;
            r_value <= n_value;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/mrd_back.sv */
`default_nettype none

module mrd_back #(
    parameter int ELECTRODE_COUNT = 16,
    parameter int NEEDLE_COUNT    = 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  mrd_pkg::t_rec      i_rec,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_stall,
    output logic [3:0]         o_record_kind,
    output logic signed [8:0]  o_source_electrode,
    output logic signed [8:0]  o_sink_electrode,
    output logic signed [8:0]  o_measure_electrode,
    output logic [31:0]        o_first_value,
    output logic [31:0]        o_second_value,
    output logic               o_is_complex
);
    import mrd_pkg::*;

    localparam logic [8:0] LIMIT = 9'(ELECTRODE_COUNT + NEEDLE_COUNT);
    localparam logic [8:0] NEG_ONE = '1;

    function automatic logic [8:0] checked(input logic [7:0] b);
        return ({1'b0, b} <= LIMIT) ? {1'b0, b} : NEG_ONE;
    endfunction

    logic       r_valid;
    logic [8:0] n_meas;

    assign o_pop   = i_q_valid & (~r_valid | ~i_stall);
    assign o_valid = r_valid;

    always_comb begin
        case (i_rec.kind) inside
            KIND_IMP_MAG, KIND_IMP_CPLX: n_meas = NEG_ONE;
            KIND_EIT:                    n_meas = {1'b0, i_rec.meas};
            default:                     n_meas = checked(i_rec.meas);
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_record_kind       <= i_rec.kind;
            o_source_electrode  <= checked(i_rec.src);
            o_sink_electrode    <= checked(i_rec.snk);
            o_measure_electrode <= n_meas;
            o_first_value       <= i_rec.value[31:0];
            o_second_value      <= i_rec.cplx ? i_rec.value[63:32] : 32'd0;
            o_is_complex        <= i_rec.cplx;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/measurement_record_deframer.sv */
// Channel | Direction | Handshake                  | Payload
// in      | input     | i_in_valid / o_in_stall    | i_rx_byte
// out     | output    | o_out_valid / i_out_stall  | o_record_kind .. o_is_complex
//
// One byte per cycle is taken while o_in_stall is low; once its last byte is taken, a record
// moves from front assembly through the four-entry record queue into the output register.
// o_in_stall rises only while the record queue is full.
// i_rst_n is synchronous, active low; it empties the queue and drops o_out_valid.
// A stalled result holds in the output register while later records queue up.
`default_nettype none

module measurement_record_deframer #(
    parameter int ELECTRODE_COUNT = 16,
    parameter int NEEDLE_COUNT    = 1
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_stall,
    input  wire logic [7:0]   i_rx_byte,
    output logic              o_out_valid,
    input  wire logic         i_out_stall,
    output logic [3:0]        o_record_kind,
    output logic signed [8:0] o_source_electrode,
    output logic signed [8:0] o_sink_electrode,
    output logic signed [8:0] o_measure_electrode,
    output logic [31:0]       o_first_value,
    output logic [31:0]       o_second_value,
    output logic              o_is_complex
);
    import mrd_pkg::*;

    logic q_full, q_push, q_valid, q_pop;
    t_rec push_rec, head_rec;

    mrd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_byte  (i_rx_byte),
        .i_full  (q_full),
        .o_stall (o_in_stall),
        .o_push  (q_push),
        .o_rec   (push_rec)
    );

    mrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rec   (head_rec),
        .i_pop   (q_pop)
    );

    mrd_back #(
        .ELECTRODE_COUNT (ELECTRODE_COUNT),
        .NEEDLE_COUNT    (NEEDLE_COUNT)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_valid           (q_valid),
        .i_rec               (head_rec),
        .o_pop               (q_pop),
        .o_valid             (o_out_valid),
        .i_stall             (i_out_stall),
        .o_record_kind       (o_record_kind),
        .o_source_electrode  (o_source_electrode),
        .o_sink_electrode    (o_sink_electrode),
        .o_measure_electrode (o_measure_electrode),
        .o_first_value       (o_first_value),
        .o_second_value      (o_second_value),
        .o_is_complex        (o_is_complex)
    );

endmodule

`default_nettype wire

/* hw/rtl/mrd_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module mrd_checker (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         o_out_valid,
    input wire logic         i_out_stall,
    input wire logic [3:0]   o_record_kind,
    input wire logic [8:0]   o_source_electrode,
    input wire logic [8:0]   o_sink_electrode,
    input wire logic [8:0]   o_measure_electrode,
    input wire logic [31:0]  o_first_value,
    input wire logic [31:0]  o_second_value,
    input wire logic         o_is_complex
);
    import mrd_pkg::*;

    logic [67:0] out_word;
    logic        empty_kind;
    logic        zero_fields;
    logic        cplx_kind;
    logic        imp_kind;

    assign out_word    = {o_record_kind, o_first_value, o_second_value};
    assign empty_kind  = (o_record_kind == KIND_END) || (o_record_kind == KIND_BAD);
    assign zero_fields = (o_source_electrode == 9'd0) && (o_sink_electrode == 9'd0)
                       && (o_measure_electrode == 9'd0) && (o_first_value == 32'd0)
                       && !o_is_complex;
    assign cplx_kind   = (o_record_kind == KIND_VOLT_CPLX) || (o_record_kind == KIND_IMP_CPLX)
                       || (o_record_kind == KIND_OTHER_CPLX);
    assign imp_kind    = (o_record_kind == KIND_IMP_MAG) || (o_record_kind == KIND_IMP_CPLX);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(out_word))
    `ASSERT_IMPL(a_kind_range, i_clk, i_rst_n, o_out_valid, o_record_kind <= KIND_BAD)
    `ASSERT_IMPL(a_empty_rec, i_clk, i_rst_n, o_out_valid && empty_kind, zero_fields)
    `ASSERT_IMPL(a_cplx_kind, i_clk, i_rst_n, o_out_valid, o_is_complex ? cplx_kind : (o_second_value == 32'd0))
    `ASSERT_IMPL(a_imp_meas, i_clk, i_rst_n, o_out_valid && imp_kind, o_measure_electrode == 9'h1FF)

endmodule

bind measurement_record_deframer mrd_checker u_chk (.*);

`default_nettype wire
